// ===== hdl/ptrig_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrig_pkg
// Shared types and fixed constants for the parabolic trig core.
// ----------------------------------------------------------------------------
package ptrig_pkg;

  localparam int INT_FRAC = 24;  // internal fraction bits of sine/cosine
  localparam int TW       = 17;  // reduced angle width
  localparam int GW       = 48;  // parabola slope term width
  localparam int VW       = 41;  // refined value width (Q24)
  localparam int QW       = 32;  // quotient bits

  localparam longint unsigned PI_Q30       = 64'd3373259426;
  localparam longint unsigned FOUR_PI_Q30  =
    (64'h4000_0000_0000_0000 + PI_Q30 / 64'd2) / PI_Q30;
  localparam longint unsigned FOUR_PI2_Q30 =
    (FOUR_PI_Q30 * FOUR_PI_Q30 + 64'h8000_0000) >> 32;

  typedef enum logic [1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2,
    OP_COT = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] angle;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } rsp_t;

  typedef logic [15:0] blend_t;

  // sideband travelling alongside the divider
  typedef struct packed {
    logic        is_div;
    logic [31:0] direct;
    logic        sat;
    logic        dz;
    logic        neg;
    logic        num_neg;
    logic        ovf;
  } side_t;

endpackage

// ===== hdl/ptrig_if.sv =====
// ----------------------------------------------------------------------------
// ptrig_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ptrig_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/parabolic_trig_approx_core.sv =====
// ----------------------------------------------------------------------------
// parabolic_trig_approx_core
// Parabolic sine/cosine/tangent/cotangent evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Stages: input stage, 7 sine stages, 1 prepare stage, 32 divider stages,
//   output register, from input transfer to result valid.
// Throughput: one item per cycle unless a result waits unread; the 32-stage
//   divider takes a quotient each unstalled cycle; no datapath stage iterates.
// Reset: synchronous, active high; clears all valid bits and loads the blend
//   factor with 14746 (about 0.225). No clearing pass.
// ----------------------------------------------------------------------------
module parabolic_trig_approx_core #(
  parameter int ANGLE_FRAC_BITS  = 11,
  parameter int RESULT_FRAC_BITS = 15
) (
  input  logic     clk,
  input  logic     rst,
  ptrig_if.sink    cmd,
  ptrig_if.source  rsp,
  ptrig_if.sink    cfg
);

  localparam int TW  = ptrig_pkg::TW;
  localparam int VW  = ptrig_pkg::VW;
  localparam int VW1 = VW + 1;
  localparam int QW  = ptrig_pkg::QW;
  localparam int NW  = VW + RESULT_FRAC_BITS;
  localparam int RS  = ptrig_pkg::INT_FRAC - RESULT_FRAC_BITS;
  localparam int SD  = 7;  // sine pipeline depth

  // pi, 2pi, pi/2 in the angle format, rounded to nearest
  localparam logic signed [TW-1:0] PI_A = TW'((ptrig_pkg::PI_Q30 +
    (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
  localparam logic [TW-1:0] TWO_PI_A = TW'((ptrig_pkg::PI_Q30 +
    (64'd1 << (28 - ANGLE_FRAC_BITS))) >> (29 - ANGLE_FRAC_BITS));
  localparam logic [TW-1:0] HALF_PI_A = TW'((ptrig_pkg::PI_Q30 +
    (64'd1 << (30 - ANGLE_FRAC_BITS))) >> (31 - ANGLE_FRAC_BITS));

  localparam logic signed [VW1-1:0] RND_O  = VW1'((64'd1 << RS) >> 1);
  localparam logic signed [VW1-1:0] I32MAX = VW1'(64'sd2147483647);
  localparam logic signed [VW1-1:0] I32MIN = VW1'(-64'sd2147483648);

  // single reduction by 2pi when above pi; nothing below -pi
  function automatic logic signed [TW-1:0] reduce(input logic signed [TW-1:0] x);
    logic signed [TW-1:0] y;
    y = x;
    if (x > PI_A) begin
      y = x - TWO_PI_A;
    end
    return y;
  endfunction

  // global advance: the pipe moves whenever the output register is empty or being taken
  logic en;
  logic out_v;
  ptrig_pkg::rsp_t out_data;

  assign en        = !out_v || rsp.ready;
  assign cmd.ready = en;
  assign rsp.valid = out_v;
  assign rsp.data  = out_data;

  // blend factor register; write channel always ready
  ptrig_pkg::blend_t blend;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend <= 16'd14746;
    end else if (cfg.valid) begin
      blend <= cfg.data;
    end
  end

  // input stage: angle reduction for both sine and cosine arguments
  logic signed [TW-1:0] a_ext;
  logic signed [TW-1:0] ts0, tc0;
  logic [1:0]           op_d  [SD+1];
  logic                 vld_d [SD+1];

  assign a_ext = TW'(cmd.data.angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d[0] <= 1'b0;
    end else if (en) begin
      vld_d[0] <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ts0      <= reduce(a_ext);
      tc0      <= reduce(a_ext + HALF_PI_A);
      op_d[0]  <= cmd.data.op;
    end
  end

  // op and valid follow the sine pipeline
  for (genvar i = 1; i <= SD; i++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[i] <= 1'b0;
      end else if (en) begin
        vld_d[i] <= vld_d[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_d[i] <= op_d[i-1];
      end
    end
  end

  // sine and cosine evaluated side by side
  logic signed [VW-1:0] s_v, c_v;
  logic                 s_sat, c_sat;

  ptrig_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sin (
    .clk   (clk),
    .en    (en),
    .t     (ts0),
    .blend (blend),
    .v     (s_v),
    .sat   (s_sat)
  );

  ptrig_sine #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cos (
    .clk   (clk),
    .en    (en),
    .t     (tc0),
    .blend (blend),
    .v     (c_v),
    .sat   (c_sat)
  );

  // prepare stage: direct rounding for sin/cos, operand set-up for the divide
  logic                 is_div;
  logic signed [VW-1:0] dsrc, num, den;
  logic signed [VW1-1:0] drnd, dsh;
  logic [31:0]          direct;
  logic                 dsat;
  logic [VW-1:0]        num_mag, den_mag;
  logic [NW-1:0]        nfull, nhi;
  ptrig_pkg::side_t     side_p;

  always_comb begin
    is_div = (op_d[SD] == ptrig_pkg::OP_TAN) || (op_d[SD] == ptrig_pkg::OP_COT);
    dsrc   = (op_d[SD] == ptrig_pkg::OP_COS) ? c_v : s_v;
    drnd   = VW1'(dsrc) + RND_O;
    dsh    = drnd >>> RS;
    dsat   = 1'b0;
    if (dsh > I32MAX) begin
      direct = 32'h7fff_ffff;
      dsat   = 1'b1;
    end else if (dsh < I32MIN) begin
      direct = 32'h8000_0000;
      dsat   = 1'b1;
    end else begin
      direct = 32'(dsh);
    end

    num     = (op_d[SD] == ptrig_pkg::OP_TAN) ? s_v : c_v;
    den     = (op_d[SD] == ptrig_pkg::OP_TAN) ? c_v : s_v;
    num_mag = num[VW-1] ? VW'(-num) : VW'(num);
    den_mag = den[VW-1] ? VW'(-den) : VW'(den);
    nfull   = NW'(num_mag) << RESULT_FRAC_BITS;
    nhi     = nfull >> QW;

    side_p.is_div  = is_div;
    side_p.direct  = direct;
    side_p.sat     = s_sat || c_sat || (!is_div && dsat);
    side_p.dz      = (den_mag == '0);
    side_p.neg     = num[VW-1] ^ den[VW-1];
    side_p.num_neg = num[VW-1];
    // quotient needs more than 32 bits
    side_p.ovf     = nhi >= NW'(den_mag);
  end

  logic                 vld_p;
  logic [VW-1:0]        rem_p, den_p;
  logic [QW-1:0]        nlo_p;
  ptrig_pkg::side_t     side_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= vld_d[SD];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_p  <= VW'(nhi);
      den_p  <= den_mag;
      nlo_p  <= nfull[QW-1:0];
      side_r <= side_p;
    end
  end

  // quotient pipeline
  logic             div_v;
  logic [QW-1:0]    quo;
  ptrig_pkg::side_t side_q;

  ptrig_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld_p),
    .rem       (rem_p),
    .den       (den_p),
    .nlo       (nlo_p),
    .side      (side_r),
    .out_valid (div_v),
    .quo       (quo),
    .side_out  (side_q)
  );

  // output stage: sign, saturation and status
  ptrig_pkg::rsp_t res_next;

  always_comb begin
    res_next.result = side_q.direct;
    res_next.status = side_q.sat ? ptrig_pkg::ST_SAT : ptrig_pkg::ST_OK;
    if (side_q.is_div) begin
      if (side_q.dz) begin
        res_next.result = side_q.num_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        res_next.status = ptrig_pkg::ST_DIVZ;
      end else if (side_q.ovf) begin
        res_next.result = side_q.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        res_next.status = ptrig_pkg::ST_SAT;
      end else if (side_q.neg) begin
        if (quo > 32'h8000_0000) begin
          res_next.result = 32'sh8000_0000;
          res_next.status = ptrig_pkg::ST_SAT;
        end else begin
          res_next.result = $signed(32'd0 - quo);
        end
      end else if (quo[QW-1]) begin
        res_next.result = 32'sh7fff_ffff;
        res_next.status = ptrig_pkg::ST_SAT;
      end else begin
        res_next.result = $signed(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_next;
    end
  end

endmodule

// ===== hdl/ptrig_sine.sv =====
// ----------------------------------------------------------------------------
// ptrig_sine
// Seven-stage parabolic sine with refinement, Q24 out.
// ----------------------------------------------------------------------------
module ptrig_sine #(
  parameter int ANGLE_FRAC_BITS = 11
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ptrig_pkg::TW-1:0]  t,
  input  logic [15:0]                      blend,
  output logic signed [ptrig_pkg::VW-1:0]  v,
  output logic                             sat
);

  localparam int TW  = ptrig_pkg::TW;
  localparam int GW  = ptrig_pkg::GW;
  localparam int VW  = ptrig_pkg::VW;
  localparam int PW  = 47;
  localparam int AW  = TW + GW;
  localparam int AW1 = AW + 1;
  localparam int MW  = VW + 17;
  localparam int RSH = 30 + 2 * ANGLE_FRAC_BITS - ptrig_pkg::INT_FRAC;

  localparam logic signed [GW-1:0]  F_SH  = GW'(ptrig_pkg::FOUR_PI_Q30 << ANGLE_FRAC_BITS);
  localparam logic [29:0]           F2    = 30'(ptrig_pkg::FOUR_PI2_Q30);
  localparam logic signed [AW1-1:0] RND_R = AW1'(64'd1 << (RSH - 1));
  localparam logic signed [AW1-1:0] R_LIM = AW1'(64'sd2147483647);
  localparam logic signed [63:0]    RND_D = 64'sd1 <<< (ptrig_pkg::INT_FRAC - 1);
  localparam logic signed [MW-1:0]  RND_M = MW'(32768);

  logic [TW-1:0]          tmag;
  logic [PW-1:0]          prod;
  logic signed [GW-1:0]   g1;
  logic signed [TW-1:0]   t1;
  logic signed [AW-1:0]   acc2;
  logic signed [AW1-1:0]  accr;
  logic signed [AW1-1:0]  ash;
  logic signed [31:0]     r3, r4, r5, r6;
  logic                   sat3, sat4, sat5, sat6;
  logic signed [31:0]     rmag;
  logic signed [63:0]     p4;
  logic signed [63:0]     pr;
  logic signed [63:0]     d;
  logic signed [VW-1:0]   diff5;
  logic signed [MW-1:0]   m6;
  logic signed [MW-1:0]   mr;
  logic signed [MW-1:0]   mq;

  // stage 1: slope term 4/pi*2^A - 4/pi^2*|t|
  always_comb begin
    tmag = t[TW-1] ? TW'(-t) : TW'(t);
    prod = PW'(F2) * PW'(tmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= F_SH - $signed(GW'(prod));
      t1 <= t;
    end
  end

  // stage 2: parabola
  always_ff @(posedge clk) begin
    if (en) begin
      acc2 <= AW'(t1) * AW'(g1);
    end
  end

  // stage 3: round to Q24, clamp
  always_comb begin
    accr = AW1'(acc2) + RND_R;
    ash  = accr >>> RSH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ash > R_LIM) begin
        r3   <= 32'sh7fff_ffff;
        sat3 <= 1'b1;
      end else if (ash < -R_LIM) begin
        r3   <= -32'sh7fff_ffff;
        sat3 <= 1'b1;
      end else begin
        r3   <= 32'(ash);
        sat3 <= 1'b0;
      end
    end
  end

  // stage 4: r*|r|
  assign rmag = r3[31] ? -r3 : r3;

  always_ff @(posedge clk) begin
    if (en) begin
      p4   <= 64'(r3) * 64'(rmag);
      r4   <= r3;
      sat4 <= sat3;
    end
  end

  // stage 5: round and take difference
  always_comb begin
    pr = p4 + RND_D;
    d  = pr >>> ptrig_pkg::INT_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff5 <= $signed(d[VW-1:0]) - VW'(r4);
      r5    <= r4;
      sat5  <= sat4;
    end
  end

  // stage 6: weight
  always_ff @(posedge clk) begin
    if (en) begin
      m6   <= MW'(diff5) * MW'($signed({1'b0, blend}));
      r6   <= r5;
      sat6 <= sat5;
    end
  end

  // stage 7: final sum
  always_comb begin
    mr = m6 + RND_M;
    mq = mr >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v   <= VW'(r6) + VW'(mq);
      sat <= sat6;
    end
  end

endmodule

// ===== hdl/ptrig_div.sv =====
// ----------------------------------------------------------------------------
// ptrig_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptrig_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [ptrig_pkg::VW-1:0]        rem,
  input  logic [ptrig_pkg::VW-1:0]        den,
  input  logic [ptrig_pkg::QW-1:0]        nlo,
  input  ptrig_pkg::side_t                side,
  output logic                            out_valid,
  output logic [ptrig_pkg::QW-1:0]        quo,
  output ptrig_pkg::side_t                side_out
);

  localparam int VW = ptrig_pkg::VW;
  localparam int QW = ptrig_pkg::QW;

  logic                   vld_a  [QW+1];
  logic [VW-1:0]          rem_a  [QW+1];
  logic [VW-1:0]          den_a  [QW+1];
  logic [QW-1:0]          nlo_a  [QW+1];
  logic [QW-1:0]          q_a    [QW+1];
  ptrig_pkg::side_t       side_a [QW+1];

  assign vld_a[0]  = in_valid;
  assign rem_a[0]  = rem;
  assign den_a[0]  = den;
  assign nlo_a[0]  = nlo;
  assign q_a[0]    = '0;
  assign side_a[0] = side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_a[k], nlo_a[k][QW-1]};
      ge    = trial >= {1'b0, den_a[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[k+1] <= 1'b0;
      end else if (en) begin
        vld_a[k+1] <= vld_a[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[k+1]  <= ge ? VW'(trial - {1'b0, den_a[k]}) : VW'(trial);
        den_a[k+1]  <= den_a[k];
        nlo_a[k+1]  <= {nlo_a[k][QW-2:0], 1'b0};
        q_a[k+1]    <= {q_a[k][QW-2:0], ge};
        side_a[k+1] <= side_a[k];
      end
    end
  end

  assign out_valid = vld_a[QW];
  assign quo       = q_a[QW];
  assign side_out  = side_a[QW];

endmodule

// ===== verif/tb_parabolic_trig_approx_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parabolic_trig_approx_core
// Self-checking bench for the parabolic sine/cosine/tangent/cotangent core.
// Commands go in on a valid/ready channel. Each accepted command is run
// through a fixed-point model of the core, or uses a typed-in answer; it is
// queued and compared with the next response transfer. Blend factor
// settings and idle/stall mixes change between phases. One phase holds the
// response side off for a long stretch so the pipe fills and stalls input.
// ----------------------------------------------------------------------------
module tb_parabolic_trig_approx_core;

  // fixed-point constants, angle format Q4.11
  localparam int AFB = 11;
  localparam int RFB = 15;
  localparam int IFB = 24;
  localparam longint unsigned PI_Q30_U  = 64'd3373259426;
  localparam longint unsigned K_LIN_U   = (64'h4000_0000_0000_0000 + PI_Q30_U / 2) / PI_Q30_U;
  localparam longint unsigned K_SQ_U    = (K_LIN_U * K_LIN_U + 64'h8000_0000) >> 32;
  localparam longint K_LIN   = longint'(K_LIN_U);
  localparam longint K_SQ    = longint'(K_SQ_U);
  localparam longint PI_ANG  = longint'((PI_Q30_U + (64'd1 << (29 - AFB))) >> (30 - AFB));
  localparam longint TWO_PI  = longint'((PI_Q30_U + (64'd1 << (28 - AFB))) >> (29 - AFB));
  localparam longint HALF_PI = longint'((PI_Q30_U + (64'd1 << (30 - AFB))) >> (31 - AFB));
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int LONG_HOLD = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptrig_if #(.T(ptrig_pkg::cmd_t))   cmd_ch ();
  ptrig_if #(.T(ptrig_pkg::rsp_t))   rsp_ch ();
  ptrig_if #(.T(ptrig_pkg::blend_t)) cfg_ch ();

  parabolic_trig_approx_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    ptrig_pkg::op_t op;
    logic [15:0]    angle;
    bit             known;   // expected answer typed in below
    logic [31:0]    res;
    logic [1:0]     st;
  } dir_row_t;

  ptrig_pkg::rsp_t   trig_expected[$];
  dir_row_t          dir_rows[$];
  ptrig_pkg::blend_t blend_cur;
  int       fail_count  = 0;
  int       send_idle   = 0;  // percent of cycles the command side idles
  int       rsp_stall   = 0;  // percent of cycles the response side stalls
  int       hold_req    = 0;  // bumped to request a long response hold-off
  int       hold_seen   = 0;
  int       hold_left   = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point model
  // ---------------------------------------------------------------------------
  // shift right, rounding half up (toward +inf at ties); n is never 0 here
  function automatic longint rnd_shr(input longint x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // parabolic sine of t (angle format), refined, result in Q24
  function automatic longint sine_q24(input longint t, input longint p, inout bit sat);
    longint mag, acc, r, rm, d;
    if (t > PI_ANG) t = t - TWO_PI;  // single reduction only, nothing below -pi
    mag = (t < 0) ? -t : t;
    acc = K_LIN * t * (64'sd1 <<< AFB) - K_SQ * (t * mag);
    r = rnd_shr(acc, 30 + 2 * AFB - IFB);
    if (r > S32_MAX) begin
      r = S32_MAX;
      sat = 1'b1;
    end else if (r < -S32_MAX) begin
      r = -S32_MAX;
      sat = 1'b1;
    end
    rm = (r < 0) ? -r : r;
    d = rnd_shr(r * rm, IFB);
    return r + rnd_shr((d - r) * p, 16);
  endfunction

  function automatic longint clip32(input longint x, inout bit sat);
    if (x > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return x;
  endfunction

  // magnitude quotient in result format, sign applied afterwards
  function automatic longint quot(input longint num, input longint den,
                                  inout bit sat, inout bit dz);
    longint unsigned un, ud, q;
    bit neg;
    if (den == 0) begin
      dz = 1'b1;
      return (num >= 0) ? S32_MAX : S32_MIN;
    end
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << RFB) / ud;
    if (neg) begin
      if (q > 64'd2147483648) begin
        sat = 1'b1;
        return S32_MIN;
      end
      return -longint'(q);
    end
    return clip32(longint'(q), sat);
  endfunction

  function automatic ptrig_pkg::rsp_t trig_predict(input ptrig_pkg::op_t op,
                                                   input logic signed [15:0] angle,
                                                   input ptrig_pkg::blend_t blend);
    ptrig_pkg::rsp_t o;
    bit     sat, dz;
    longint s, c, v, p, a;
    sat = 1'b0;
    dz  = 1'b0;
    p = longint'({48'd0, blend});
    a = longint'(angle);
    s = sine_q24(a, p, sat);
    c = sine_q24(a + HALF_PI, p, sat);  // cosine flags count for every op
    case (op)
      ptrig_pkg::OP_SIN: v = clip32(rnd_shr(s, IFB - RFB), sat);
      ptrig_pkg::OP_COS: v = clip32(rnd_shr(c, IFB - RFB), sat);
      ptrig_pkg::OP_TAN: v = quot(s, c, sat, dz);
      default:           v = quot(c, s, sat, dz);
    endcase
    o.result = v[31:0];
    o.status = dz ? ptrig_pkg::ST_DIVZ : (sat ? ptrig_pkg::ST_SAT : ptrig_pkg::ST_OK);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // one command transfer; expectation is queued at the accepting edge
  task automatic send_cmd(input ptrig_pkg::op_t op, input logic [15:0] angle,
                          input bit known, input ptrig_pkg::rsp_t fixed);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.data.op    <= op;
    cmd_ch.data.angle <= angle;
    do @(posedge clk); while (!cmd_ch.ready);
    trig_expected.push_back(known ? fixed : trig_predict(op, angle, blend_cur));
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (trig_expected.size() != 0) @(posedge clk);
  endtask

  // register write only once the pipeline is empty
  task automatic write_blend(input ptrig_pkg::blend_t v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    blend_cur = v;
  endtask

  // angles weighted toward the interesting regions
  function automatic logic [15:0] pick_angle();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2: return 16'($urandom);
      3, 4:    return 16'($urandom_range(2 * PI_ANG) - PI_ANG);
      5:       return 16'($urandom_range(16) - 8);
      6:       return 16'(HALF_PI + $urandom_range(16) - 8);
      7:       return 16'(-HALF_PI + $urandom_range(16) - 8);
      8:       return 16'(PI_ANG + $urandom_range(8) - 4);
      default: return 16'(-PI_ANG + $urandom_range(8) - 4);
    endcase
  endfunction

  task automatic send_random(input int n);
    ptrig_pkg::rsp_t none;
    none = '0;
    repeat (n) send_cmd(ptrig_pkg::op_t'($urandom_range(3)), pick_angle(), 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall);
    end
  end

  // response checker
  always @(posedge clk) begin
    ptrig_pkg::rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (trig_expected.size() == 0) begin
        $error("unexpected response: result %h status %0d",
               rsp_ch.data.result, rsp_ch.data.status);
        fail_count++;
      end else begin
        want = trig_expected.pop_front();
        if (rsp_ch.data.result !== want.result) begin
          $error("result: expected %h, got %h", want.result, rsp_ch.data.result);
          fail_count++;
        end
        if (rsp_ch.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.data.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    ptrig_pkg::rsp_t fixed;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    blend_cur    = 16'd14746;

    // directed rows: zero angle, the tangent/cotangent poles, range extremes
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'h0000, 1, 32'h0000_0000, ptrig_pkg::ST_OK});
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'h0000, 1, 32'h0000_0000, ptrig_pkg::ST_OK});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'h0000, 1, 32'h7FFF_FFFF, ptrig_pkg::ST_DIVZ});
    dir_rows.push_back('{ptrig_pkg::OP_COS, 16'h0000, 0, '0, '0});
    // cosine argument lands exactly on zero: tangent divides by zero, sine < 0
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'(-HALF_PI), 1, 32'h8000_0000,
                         ptrig_pkg::ST_DIVZ});
    dir_rows.push_back('{ptrig_pkg::OP_COS, 16'(-HALF_PI), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'(-HALF_PI), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'(HALF_PI), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'(HALF_PI), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'(HALF_PI), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'(PI_ANG), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'(PI_ANG + 1), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'(PI_ANG), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'(-PI_ANG), 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'h7FFF, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COS, 16'h7FFF, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'h7FFF, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'h7FFF, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_SIN, 16'h8000, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COS, 16'h8000, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'h8000, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'h8000, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_TAN, 16'h0001, 0, '0, '0});
    dir_rows.push_back('{ptrig_pkg::OP_COT, 16'hFFFF, 0, '0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 0: blend at reset value, no idling, then a long hold-off
    foreach (dir_rows[i]) begin
      fixed.result = dir_rows[i].res;
      fixed.status = dir_rows[i].st;
      send_cmd(dir_rows[i].op, dir_rows[i].angle, dir_rows[i].known, fixed);
    end
    hold_req++;
    send_random(100);

    // remaining phases: blend extremes and a random setting, idle mixes
    write_blend(16'd0);
    send_idle = 60;
    rsp_stall = 0;
    send_random(285);

    write_blend(16'hFFFF);
    send_idle = 0;
    rsp_stall = 60;
    send_random(285);

    write_blend(16'($urandom));
    send_idle = 32;
    rsp_stall = 32;
    send_random(285);

    write_blend(16'd14746);
    send_idle = 0;
    rsp_stall = 0;
    send_random(285);

    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
